>>> design/sse_pkg.sv
// Shared types and codes for the sorted set engine.
`timescale 1ns / 1ps
`default_nettype none
package sse_pkg;

	// Request action codes.
	localparam logic [2:0] ACT_INS_A = 3'd0;
	localparam logic [2:0] ACT_INS_B = 3'd1;
	localparam logic [2:0] ACT_INTER = 3'd2;
	localparam logic [2:0] ACT_UNION = 3'd3;
	localparam logic [2:0] ACT_DIFF  = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_DUP      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_MEMBER   = 2'd3;

	// Chain operation codes.
	typedef logic [1:0] chain_op_t;
	localparam chain_op_t OP_HOLD = 2'd0;
	localparam chain_op_t OP_INS  = 2'd1;
	localparam chain_op_t OP_ROT  = 2'd2;

	// Control bundle sent from the sequencer to one chain.
	typedef struct packed {
		chain_op_t   op;
		logic [31:0] value;
	} chain_ctrl_t;

endpackage
`default_nettype wire

>>> design/sse_cell.sv
// One storage cell of a sorted chain: holds one set entry.
`timescale 1ns / 1ps
`default_nettype none
module sse_cell (
	input  wire               clk,
	input  sse_pkg::chain_ctrl_t ctrl,
	input  wire  [31:0]       left_data,
	input  wire               left_lt,
	input  wire  [31:0]       right_data,
	input  wire  [31:0]       head_data,
	input  wire               tail,
	input  wire               live,
	output logic [31:0]       data_q,
	output logic              lt,
	output logic              eq
);
	import sse_pkg::*;

	// Compare the held entry against the value being inserted.
	assign lt = live && ($signed(data_q) < $signed(ctrl.value));
	assign eq = live && (data_q == ctrl.value);

	// Keep, take the new value, shift from the left, or rotate from the right.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INS: begin
				if (!lt) begin
					data_q <= left_lt ? ctrl.value : left_data;
				end
			end
			OP_ROT: begin
				data_q <= tail ? head_data : right_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/sse_chain.sv
// A row of cells holding one sorted set, with its size counter.
`timescale 1ns / 1ps
`default_nettype none
module sse_chain #(
	parameter int CAP = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  sse_pkg::chain_ctrl_t      ctrl,
	output logic [31:0]               head,
	output logic [$clog2(CAP+1)-1:0]  size_q,
	output logic                      dup,
	output logic                      full
);
	import sse_pkg::*;

	localparam int SW = $clog2(CAP + 1);

	logic [31:0] data [CAP];
	logic [CAP-1:0] lt_v;
	logic [CAP-1:0] eq_v;

	// Cells: insertion shifts right, rotation moves the head to the tail.
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [31:0] left_d;
		logic [31:0] right_d;
		logic        left_l;
		if (i == 0) begin : g_first
			assign left_d = ctrl.value;
			assign left_l = 1'b1;
		end else begin : g_mid
			assign left_d = data[i-1];
			assign left_l = lt_v[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign right_d = data[i];
		end else begin : g_inner
			assign right_d = data[i+1];
		end
		sse_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  (left_d),
			.left_lt    (left_l),
			.right_data (right_d),
			.head_data  (data[0]),
			.tail       (SW'(i + 1) == size_q),
			.live       (SW'(i) < size_q),
			.data_q     (data[i]),
			.lt         (lt_v[i]),
			.eq         (eq_v[i])
		);
	end

	assign head = data[0];
	assign dup  = |eq_v;
	assign full = size_q >= SW'(CAP);

	// Size grows by one on every performed insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (ctrl.op == OP_INS) begin
			size_q <= size_q + SW'(1);
		end
	end

endmodule
`default_nettype wire

>>> design/sorted_set_engine.sv
// Sorted set engine top level: request sequencer, two cell chains, result register.
// An insert result is registered from the S_INS state once the result register is free; the
// next request is taken back in S_IDLE. A query walks both chains twice (count, then emit),
// one merge step per cycle for each member of A union B; an emit step waits while the result
// register is held.
// Reset clears both set sizes and the sequencer; stored entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_engine #(
	parameter int CAPACITY = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [2:0]        action,
	input  wire  [31:0]       value,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [31:0]       element,
	output logic              last_flag,
	output logic              empty_flag,
	output logic [1:0]        status,
	output logic [6:0]        size_count
);
	import sse_pkg::*;

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(2 * CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INS   = 3'd1;
	localparam logic [2:0] S_CNT   = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_EMPTY = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    act_q;
	logic [31:0]   val_q;
	logic [SW-1:0] ia_q, jb_q;
	logic [CW-1:0] cnt_q, ecnt_q;

	chain_ctrl_t   ctrl_a, ctrl_b;
	logic [31:0]   head_a, head_b;
	logic [SW-1:0] size_a, size_b;
	logic          dup_a, dup_b, full_a, full_b;

	sse_chain #(.CAP(CAPACITY)) u_chain_a (
		.clk (clk), .arst_n (arst_n), .ctrl (ctrl_a),
		.head (head_a), .size_q (size_a), .dup (dup_a), .full (full_a)
	);
	sse_chain #(.CAP(CAPACITY)) u_chain_b (
		.clk (clk), .arst_n (arst_n), .ctrl (ctrl_b),
		.head (head_b), .size_q (size_b), .dup (dup_b), .full (full_b)
	);

	// Merge step decisions.
	logic a_rem, b_rem, take_a, take_b, keep, walk_done, slot_free, tgt_a;
	logic [1:0] ins_st;
	logic [SW-1:0] tgt_size;
	logic [31:0] pick;

	assign a_rem     = ia_q < size_a;
	assign b_rem     = jb_q < size_b;
	assign walk_done = !a_rem && !b_rem;
	assign take_a    = a_rem && (!b_rem || ($signed(head_a) <= $signed(head_b)));
	assign take_b    = b_rem && (!a_rem || ($signed(head_b) <= $signed(head_a)));
	assign pick      = take_a ? head_a : head_b;
	assign slot_free = !out_valid || out_ready;
	assign tgt_a     = act_q == ACT_INS_A;
	assign tgt_size  = tgt_a ? size_a : size_b;

	always_comb begin
		case (act_q)
			ACT_INTER: keep = take_a && take_b;
			ACT_UNION: keep = 1'b1;
			ACT_DIFF:  keep = take_a && !take_b;
			default:   keep = 1'b0;
		endcase
	end

	always_comb begin
		if (tgt_a ? dup_a : dup_b) begin
			ins_st = ST_DUP;
		end else if (tgt_a ? full_a : full_b) begin
			ins_st = ST_FULL;
		end else begin
			ins_st = ST_INSERTED;
		end
	end

	// Chain controls.
	logic walk_step;
	assign walk_step = !walk_done &&
		((state_q == S_CNT) || (state_q == S_EMIT && slot_free));

	always_comb begin
		ctrl_a.value = val_q;
		ctrl_b.value = val_q;
		ctrl_a.op    = OP_HOLD;
		ctrl_b.op    = OP_HOLD;
		if (state_q == S_INS && slot_free && ins_st == ST_INSERTED) begin
			if (tgt_a) begin
				ctrl_a.op = OP_INS;
			end else begin
				ctrl_b.op = OP_INS;
			end
		end else if (walk_step) begin
			if (take_a) ctrl_a.op = OP_ROT;
			if (take_b) ctrl_b.op = OP_ROT;
		end
	end

	assign in_ready = state_q == S_IDLE;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ia_q    <= '0;
			jb_q    <= '0;
			cnt_q   <= '0;
			ecnt_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					ia_q   <= '0;
					jb_q   <= '0;
					cnt_q  <= '0;
					ecnt_q <= '0;
					if (in_valid) begin
						if (action == ACT_INS_A || action == ACT_INS_B) begin
							state_q <= S_INS;
						end else if (action == ACT_INTER || action == ACT_UNION ||
							action == ACT_DIFF) begin
							state_q <= S_CNT;
						end
					end
				end
				S_INS: begin
					if (slot_free) state_q <= S_IDLE;
				end
				S_CNT: begin
					if (walk_done) begin
						state_q <= (cnt_q == '0) ? S_EMPTY : S_EMIT;
						ia_q    <= '0;
						jb_q    <= '0;
					end else begin
						ia_q  <= ia_q + SW'(take_a);
						jb_q  <= jb_q + SW'(take_b);
						cnt_q <= cnt_q + CW'(keep);
					end
				end
				S_EMIT: begin
					if (walk_done) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						ia_q   <= ia_q + SW'(take_a);
						jb_q   <= jb_q + SW'(take_b);
						ecnt_q <= ecnt_q + CW'(keep);
					end
				end
				S_EMPTY: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action;
			val_q <= value;
		end
	end

	// Result register.
	logic load;
	always_comb begin
		case (state_q)
			S_INS:   load = slot_free;
			S_EMIT:  load = slot_free && !walk_done && keep;
			S_EMPTY: load = slot_free;
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			case (state_q)
				S_INS: begin
					element    <= val_q;
					last_flag  <= 1'b1;
					empty_flag <= 1'b0;
					status     <= ins_st;
					size_count <= 7'(tgt_size) + 7'(ins_st == ST_INSERTED);
				end
				S_EMIT: begin
					element    <= pick;
					last_flag  <= (ecnt_q + CW'(1)) == cnt_q;
					empty_flag <= 1'b0;
					status     <= ST_MEMBER;
					size_count <= 7'(cnt_q);
				end
				default: begin
					element    <= '0;
					last_flag  <= 1'b1;
					empty_flag <= 1'b1;
					status     <= ST_MEMBER;
					size_count <= '0;
				end
			endcase
		end
	end

	// Checks.
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> ecnt_q <= cnt_q)
		else $error("emitted more items than counted");
	a_size_a: assert property (@(posedge clk) disable iff (!arst_n)
		size_a <= SW'(CAPACITY))
		else $error("set A size above capacity");
	a_size_b: assert property (@(posedge clk) disable iff (!arst_n)
		size_b <= SW'(CAPACITY))
		else $error("set B size above capacity");
	a_member_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_MEMBER && !empty_flag |-> size_count != 7'd0)
		else $error("member item with zero result size");
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && walk_done |=> state_q == S_IDLE)
		else $error("emit walk did not finish");

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for the sorted set engine: random inserts and set queries.
`timescale 1ns / 1ps
`default_nettype none

// Predicts the result stream of the engine and checks each result as it arrives.
class set_scoreboard;
	logic [31:0] set_a[$];
	logic [31:0] set_b[$];
	logic [31:0] exp_element[$];
	logic        exp_last[$];
	logic        exp_empty[$];
	logic [1:0]  exp_status[$];
	logic [6:0]  exp_size[$];
	int          capacity;
	int          errors;

	function new(int cap);
		capacity = cap;
		errors = 0;
	endfunction

	function void push_result(logic [31:0] e, logic l, logic em, logic [1:0] s, logic [6:0] n);
		exp_element.insert(exp_element.size(), e);
		exp_last.insert(exp_last.size(), l);
		exp_empty.insert(exp_empty.size(), em);
		exp_status.insert(exp_status.size(), s);
		exp_size.insert(exp_size.size(), n);
	endfunction

	// Inserts into one sorted set and returns the status code.
	function logic [1:0] insert_sorted(ref logic [31:0] s[$], input logic [31:0] v);
		int pos;
		pos = 0;
		while (pos < s.size() && $signed(s[pos]) < $signed(v))
			pos++;
		if (pos < s.size() && s[pos] == v)
			return sse_pkg::ST_DUP;
		if (s.size() >= capacity)
			return sse_pkg::ST_FULL;
		s.insert(pos, v);
		return sse_pkg::ST_INSERTED;
	endfunction

	// Notes one accepted request and queues the results it must cause.
	function void note_request(logic [2:0] act, logic [31:0] v);
		logic [31:0] merged[$];
		logic [1:0]  st;
		int          i;
		int          j;
		logic        ta;
		logic        tb;
		logic [31:0] e;
		if (act == sse_pkg::ACT_INS_A) begin
			st = insert_sorted(set_a, v);
			push_result(v, 1'b1, 1'b0, st, 7'(set_a.size()));
		end else if (act == sse_pkg::ACT_INS_B) begin
			st = insert_sorted(set_b, v);
			push_result(v, 1'b1, 1'b0, st, 7'(set_b.size()));
		end else if (act == sse_pkg::ACT_INTER || act == sse_pkg::ACT_UNION ||
			act == sse_pkg::ACT_DIFF) begin
			i = 0;
			j = 0;
			while (i < set_a.size() || j < set_b.size()) begin
				if (i < set_a.size() && j < set_b.size()) begin
					ta = $signed(set_a[i]) <= $signed(set_b[j]);
					tb = $signed(set_b[j]) <= $signed(set_a[i]);
				end else begin
					ta = i < set_a.size();
					tb = j < set_b.size();
				end
				e = ta ? set_a[i] : set_b[j];
				if (act == sse_pkg::ACT_INTER && ta && tb)
					merged.insert(merged.size(), e);
				else if (act == sse_pkg::ACT_UNION)
					merged.insert(merged.size(), e);
				else if (act == sse_pkg::ACT_DIFF && ta && !tb)
					merged.insert(merged.size(), e);
				if (ta)
					i++;
				if (tb)
					j++;
			end
			if (merged.size() == 0)
				push_result(32'd0, 1'b1, 1'b1, sse_pkg::ST_MEMBER, 7'd0);
			for (int k = 0; k < merged.size(); k++)
				push_result(merged[k], k == merged.size() - 1, 1'b0, sse_pkg::ST_MEMBER,
					7'(merged.size()));
		end
	endfunction

	// Compares one accepted result against the oldest expectation.
	function void check_result(logic [31:0] e, logic l, logic em, logic [1:0] s, logic [6:0] n);
		if (exp_element.size() == 0) begin
			$display("%0t: unexpected result element=%0d", $time, $signed(e));
			errors++;
			return;
		end
		if (e !== exp_element[0]) begin
			$display("%0t: element expected %0d actual %0d", $time,
				$signed(exp_element[0]), $signed(e));
			errors++;
		end
		if (l !== exp_last[0]) begin
			$display("%0t: last_flag expected %0b actual %0b", $time, exp_last[0], l);
			errors++;
		end
		if (em !== exp_empty[0]) begin
			$display("%0t: empty_flag expected %0b actual %0b", $time, exp_empty[0], em);
			errors++;
		end
		if (s !== exp_status[0]) begin
			$display("%0t: status expected %0d actual %0d", $time, exp_status[0], s);
			errors++;
		end
		if (n !== exp_size[0]) begin
			$display("%0t: size_count expected %0d actual %0d", $time, exp_size[0], n);
			errors++;
		end
		void'(exp_element.pop_front());
		void'(exp_last.pop_front());
		void'(exp_empty.pop_front());
		void'(exp_status.pop_front());
		void'(exp_size.pop_front());
	endfunction

	function int pending();
		return exp_element.size();
	endfunction
endclass

module tb;
	localparam int CAPACITY = 32;
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = 3'd0;
	logic [31:0] value = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] element;
	logic        last_flag;
	logic        empty_flag;
	logic [1:0]  status;
	logic [6:0]  size_count;

	set_scoreboard board = new(CAPACITY);
	logic        long_hold = 1'b0;
	int          cycles = 0;
	logic [31:0] pool[$];

	sorted_set_engine #(.CAPACITY(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .element(element),
		.last_flag(last_flag), .empty_flag(empty_flag), .status(status),
		.size_count(size_count)
	);

	always #1 clk = ~clk;

	// Monitor: sample both handshakes at the edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && in_ready)
			board.note_request(action, value);
		if (out_valid && out_ready)
			board.check_result(element, last_flag, empty_flag, status, size_count);
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: stalls on a rotating pattern, with one long hold-off.
	always @(posedge clk) begin
		if (long_hold)
			out_ready <= 1'b0;
		else if (cycles % 97 < 20)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	initial begin
		wait (cycles == 3000);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Offers one request and holds it until it is taken.
	task automatic send_request(logic [2:0] act, logic [31:0] v);
		in_valid <= 1'b1;
		action <= act;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Random gap after a burst; the valid is dropped only when idling.
	task automatic gap();
		int n;
		n = $urandom_range(0, 6);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1, 2: v = pool.size() ? pool[$urandom_range(0, pool.size() - 1)] : $urandom;
			3: v = $urandom_range(0, 40) - 20;
			default: v = $urandom_range(0, 15) * 32'h1111_1111;
		endcase
		pool.insert(pool.size(), v);
		return v;
	endfunction

	task automatic random_phase(int count);
		int burst;
		int sent;
		int r;
		logic [2:0] act;
		sent = 0;
		burst = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				act = sse_pkg::ACT_INS_A;
			else if (r < 60)
				act = sse_pkg::ACT_INS_B;
			else if (r < 70)
				act = sse_pkg::ACT_INTER;
			else if (r < 80)
				act = sse_pkg::ACT_UNION;
			else if (r < 90)
				act = sse_pkg::ACT_DIFF;
			else
				act = 3'($urandom_range(5, 7));
			send_request(act, pick_value());
			if (act <= sse_pkg::ACT_DIFF)
				sent++;
			if (burst == 0) begin
				gap();
				burst = $urandom_range(1, 12);
			end else begin
				burst--;
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queries, extremes, duplicates, unused codes.
		send_request(sse_pkg::ACT_INTER, 32'hFFFF_FFFF);
		send_request(sse_pkg::ACT_UNION, 32'd0);
		send_request(sse_pkg::ACT_DIFF, 32'd0);
		send_request(sse_pkg::ACT_INS_A, 32'h8000_0000);
		send_request(sse_pkg::ACT_INS_A, 32'h7FFF_FFFF);
		send_request(sse_pkg::ACT_INS_A, 32'hFFFF_FFFF);
		send_request(sse_pkg::ACT_INS_A, 32'd0);
		send_request(sse_pkg::ACT_INS_A, 32'd0);
		send_request(sse_pkg::ACT_INS_B, 32'h7FFF_FFFF);
		send_request(sse_pkg::ACT_INS_B, 32'd1);
		send_request(3'd5, 32'd5);
		send_request(3'd6, 32'hAAAA_AAAA);
		send_request(3'd7, 32'h5555_5555);
		send_request(sse_pkg::ACT_INTER, 32'd0);
		send_request(sse_pkg::ACT_UNION, 32'd0);
		send_request(sse_pkg::ACT_DIFF, 32'd0);
		// Fill A to capacity, then a full reject and a duplicate into the full set.
		for (int k = 0; k < CAPACITY; k++)
			send_request(sse_pkg::ACT_INS_A, k * 32'h0800_0001);
		send_request(sse_pkg::ACT_INS_A, 32'h1234_5678);
		send_request(sse_pkg::ACT_INS_A, 32'h0800_0001);
		send_request(sse_pkg::ACT_UNION, 32'd0);
		send_request(sse_pkg::ACT_DIFF, 32'd0);
		in_valid <= 1'b0;

		random_phase(320);

		while (board.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
